// ===== hw/rtl/lph_pkg.sv =====
// ----------------------------------------------------------------------------
// lph_pkg
// Types and codes shared by the linear-probe hash table modules.
// ----------------------------------------------------------------------------
package lph_pkg;

    localparam int KIND_W   = 2;
    localparam int KEY_W    = 32;
    localparam int HASH_W   = 32;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;
    localparam int SLOT_W   = 2;

    localparam logic [KIND_W-1:0] KIND_PUT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GET    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] RES_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] RES_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] RES_FULL      = 2'd2;

    localparam logic [SLOT_W-1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_LIVE    = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_DELETED = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HOME,
        S_PROBE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] hash;
        logic [VAL_W-1:0]  value;
    } t_entry;

    typedef struct packed {
        logic status_we;
        logic data_we;
    } t_store_ctl;

endpackage

// ===== hw/rtl/lph_req_if.sv =====
// ----------------------------------------------------------------------------
// lph_req_if
// Request channel: kind, key, hash and value with valid/ready.
// ----------------------------------------------------------------------------
interface lph_req_if
    import lph_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash;
    logic [VAL_W-1:0]  value;

    modport source (output valid, kind, key, hash, value, input ready);
    modport sink   (input valid, kind, key, hash, value, output ready);
endinterface

// ===== hw/rtl/lph_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lph_rsp_if
// Response channel: status, found value and entry count with valid/ready.
// ----------------------------------------------------------------------------
interface lph_rsp_if
    import lph_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    found_value;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, status, found_value, entry_count, input ready);
    modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

// ===== hw/rtl/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing over SLOTS slots.
//
// Requests (i_req) carry kind (put, get, remove), key, key hash and value;
// each request gives exactly one response (o_rsp) with status, found value
// and live entry count. Both channels use valid/ready.
// One request is in flight at a time. A request goes to the home slot
// step, which waits on the hash modulo unit when SLOTS is not a power of
// two, then walks the probe path, reading 1 to SLOTS slots, before the
// response goes valid. The probe walk is set by the single slot memory
// read port, one slot per cycle. The response sits in an output register;
// i_req.ready stays low while it is waiting, so a stalled receiver holds
// off new requests. After reset the block clears the slot status memory,
// one slot a cycle, with i_req.ready low; then the table is empty.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
    import lph_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lph_req_if.sink      i_req,
    lph_rsp_if.source    o_rsp
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_pos, n_pos;
    logic [IDX_W-1:0]    r_cnt, n_cnt;
    logic [CNT_W-1:0]    r_live, n_live;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [VAL_W-1:0]    r_out_found, n_out_found;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;

    logic [KIND_W-1:0]   r_kind;
    t_entry              r_req;

    logic                accept;
    logic                home_done;
    logic [IDX_W-1:0]    home;
    t_store_ctl          store_ctl;
    logic [SLOT_W-1:0]   wr_status;
    logic [SLOT_W-1:0]   rd_status;
    t_entry              rd_entry;
    logic                last_probe;
    logic                hit;
    logic                finish;
    logic [STATUS_W-1:0] fin_status;
    logic [VAL_W-1:0]    fin_found;

    assign i_req.ready = (r_state == S_IDLE) && !r_out_valid;
    assign accept      = i_req.valid && i_req.ready;

    lph_home #(.SLOTS(SLOTS)) u_home (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_hash  (i_req.hash),
        .o_done  (home_done),
        .o_home  (home)
    );

    lph_store #(.SLOTS(SLOTS)) u_store (
        .i_clk       (i_clk),
        .i_ctl       (store_ctl),
        .i_wr_addr   (r_pos),
        .i_wr_status (wr_status),
        .i_wr_entry  (r_req),
        .i_rd_addr   (n_pos),
        .o_rd_status (rd_status),
        .o_rd_entry  (rd_entry)
    );

    assign last_probe = (r_cnt == LAST);
    assign hit = (rd_status == SLOT_LIVE) && (rd_entry.hash == r_req.hash)
                 && (rd_entry.key == r_req.key);

    always_comb begin
        n_state           = r_state;
        n_pos             = r_pos;
        n_cnt             = r_cnt;
        n_live            = r_live;
        store_ctl         = '0;
        wr_status         = SLOT_EMPTY;
        finish            = 1'b0;
        fin_status        = RES_NOT_FOUND;
        fin_found         = '0;

        case (r_state)
            S_CLEAR: begin
                store_ctl.status_we = 1'b1;
                if (r_pos == LAST) begin
                    n_pos   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_pos = r_pos + IDX_W'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_HOME;
                end
            end
            S_HOME: begin
                if (home_done) begin
                    n_pos   = home;
                    n_cnt   = '0;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                case (r_kind)
                    KIND_PUT: begin
                        if (rd_status != SLOT_LIVE) begin
                            store_ctl.status_we = 1'b1;
                            store_ctl.data_we   = 1'b1;
                            wr_status           = SLOT_LIVE;
                            n_live              = r_live + CNT_W'(1);
                            finish              = 1'b1;
                            fin_status          = RES_OK;
                        end else if (last_probe) begin
                            finish     = 1'b1;
                            fin_status = RES_FULL;
                        end
                    end
                    KIND_GET, KIND_REMOVE: begin
                        if (rd_status == SLOT_EMPTY) begin
                            finish = 1'b1;
                        end else if (hit) begin
                            finish     = 1'b1;
                            fin_status = RES_OK;
                            if (r_kind == KIND_GET) begin
                                fin_found = rd_entry.value;
                            end else begin
                                store_ctl.status_we = 1'b1;
                                wr_status           = SLOT_DELETED;
                                if (r_live != '0) begin
                                    n_live = r_live - CNT_W'(1);
                                end
                            end
                        end else if (last_probe) begin
                            finish = 1'b1;
                        end
                    end
                    default: begin
                        finish = 1'b1;
                    end
                endcase
                if (finish) begin
                    n_state = S_IDLE;
                end else begin
                    n_pos = (r_pos == LAST) ? '0 : r_pos + IDX_W'(1);
                    n_cnt = r_cnt + IDX_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        if (finish) begin
            n_out_valid  = 1'b1;
            n_out_status = fin_status;
            n_out_found  = fin_found;
            n_out_count  = COUNT_W'(n_live);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind      <= i_req.kind;
            r_req.key   <= i_req.key;
            r_req.hash  <= i_req.hash;
            r_req.value <= i_req.value;
        end
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_value = r_out_found;
    assign o_rsp.entry_count = r_out_count;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid))
        else $error("request taken while response pending");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.found_value != '0) |-> (o_rsp.status == RES_OK))
        else $error("found value on unsuccessful response");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CNT_W'(SLOTS))
        else $error("live count above table size");

    a_accept_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_HOME))
        else $error("request not followed by home slot step");

endmodule

// ===== hw/rtl/lph_home.sv =====
// ----------------------------------------------------------------------------
// lph_home
// Home slot unit: key hash modulo SLOTS. A mask for a power-of-two table,
// otherwise a reciprocal multiply, a subtraction and one correction step.
// ----------------------------------------------------------------------------
module lph_home
    import lph_pkg::*;
#(
    parameter int  SLOTS = 256,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [HASH_W-1:0] i_hash,
    output logic              o_done,
    output logic [IDX_W-1:0]  o_home
);

    if ((SLOTS & (SLOTS - 1)) == 0) begin : g_pow2
        logic [IDX_W-1:0] r_home;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_home <= '0;
            end else if (i_start) begin
                r_home <= i_hash[IDX_W-1:0];
            end
        end

        assign o_home = r_home;
        assign o_done = 1'b1;
    end else begin : g_div
        // quotient estimate is exact or one low; remainder lands below 2*SLOTS
        localparam logic [HASH_W-1:0] RECIP = HASH_W'((64'd1 << HASH_W) / SLOTS);
        localparam logic [IDX_W:0]    MOD   = (IDX_W + 1)'(SLOTS);
        localparam logic [1:0]        STEP_MUL = 2'd0;
        localparam logic [1:0]        STEP_SUB = 2'd1;
        localparam logic [1:0]        STEP_FIX = 2'd2;

        logic [HASH_W-1:0]   r_x;
        logic [HASH_W-1:0]   r_q;
        logic [IDX_W:0]      r_diff;
        logic [IDX_W-1:0]    r_rem;
        logic [1:0]          r_step;
        logic                r_busy;
        logic [2*HASH_W-1:0] prod;
        logic [IDX_W:0]      qm;

        assign prod = (2 * HASH_W)'(r_x) * (2 * HASH_W)'(RECIP);
        assign qm   = r_q[IDX_W:0] * MOD;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_busy <= 1'b0;
                r_step <= STEP_MUL;
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_MUL;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == STEP_FIX) begin
                    r_busy <= 1'b0;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_x <= i_hash;
            end else if (r_busy) begin
                case (r_step)
                    STEP_MUL: begin
                        r_q <= prod[2*HASH_W-1:HASH_W];
                    end
                    STEP_SUB: begin
                        r_diff <= r_x[IDX_W:0] - qm;
                    end
                    STEP_FIX: begin
                        r_rem <= (r_diff >= MOD) ? IDX_W'(r_diff - MOD) : r_diff[IDX_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end

        assign o_home = r_rem;
        assign o_done = !r_busy;
    end

endmodule

// ===== hw/rtl/lph_store.sv =====
// ----------------------------------------------------------------------------
// lph_store
// Slot storage: a status memory and an entry memory sharing one write
// address and one read address, read data registered.
// ----------------------------------------------------------------------------
module lph_store
    import lph_pkg::*;
#(
    parameter int  SLOTS = 256,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic              i_clk,
    input  t_store_ctl        i_ctl,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  logic [SLOT_W-1:0] i_wr_status,
    input  t_entry            i_wr_entry,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output logic [SLOT_W-1:0] o_rd_status,
    output t_entry            o_rd_entry
);

    logic [SLOT_W-1:0] r_status_mem [SLOTS];
    t_entry            r_entry_mem  [SLOTS];
    logic [SLOT_W-1:0] r_rd_status;
    t_entry            r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.status_we) begin
            r_status_mem[i_wr_addr] <= i_wr_status;
        end
        r_rd_status <= r_status_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.data_we) begin
            r_entry_mem[i_wr_addr] <= i_wr_entry;
        end
        r_rd_entry <= r_entry_mem[i_rd_addr];
    end

    assign o_rd_status = r_rd_status;
    assign o_rd_entry  = r_rd_entry;

endmodule
